// ===== src/request_deadline_slot_table_core_assert.svh =====
// Assertion macros for the request deadline slot table.
// Used by the top level; they expand to nothing when SYNTH is defined.
`ifndef REQUEST_DEADLINE_SLOT_TABLE_CORE_ASSERT_SVH
`define REQUEST_DEADLINE_SLOT_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
`define RDST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RDST_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RDST_ASSERT(lbl, clk, rst, prop, msg)
`define RDST_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== src/rdst_pkg.sv =====
// Shared types and constants for the request deadline slot table.
// No dependencies; used by every module of the block except rdst_ram.
package rdst_pkg;

   localparam logic [2:0] CMD_REGISTER = 3'd0;
   localparam logic [2:0] CMD_SET_CLASS = 3'd1;
   localparam logic [2:0] CMD_UNREGISTER = 3'd2;
   localparam logic [2:0] CMD_QUERY = 3'd3;
   localparam logic [2:0] CMD_SWEEP = 3'd4;
   localparam logic [2:0] CMD_SNAPSHOT = 3'd5;
   localparam logic [2:0] CMD_CLEAR = 3'd6;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_KILL = 2'd2;
   localparam logic [1:0] ST_COUNTER = 2'd3;

   localparam logic [2:0] CNT_REGISTERED = 3'd0;
   localparam logic [2:0] CNT_COMPLETED = 3'd1;
   localparam logic [2:0] CNT_KILLED = 3'd2;
   localparam logic [2:0] CNT_SWEEPS = 3'd3;
   localparam logic [2:0] CNT_BUSY = 3'd4;

   localparam logic [1:0] CLS_ORDINARY = 2'd0;
   localparam logic [1:0] CLS_WALLET = 2'd1;
   localparam logic [1:0] CLS_PROOF = 2'd2;
   localparam logic [1:0] CLS_MARKET = 2'd3;

   localparam logic [1:0] CSR_BASE = 2'd0;
   localparam logic [1:0] CSR_PROOF = 2'd1;
   localparam logic [1:0] CSR_WALLET = 2'd2;
   localparam logic [1:0] CSR_MARKET = 2'd3;

   localparam logic [19:0] BASE_RESET = 20'd10000;
   localparam logic [19:0] PROOF_RESET = 20'd120000;
   localparam logic [19:0] WALLET_RESET = 20'd60000;
   localparam logic [19:0] MARKET_RESET = 20'd300000;
   localparam logic [29:0] MS_TO_US = 30'd1000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] client_id;
      logic [31:0] ip_addr;
      logic [3:0]  slot_index;
      logic [1:0]  method_class;
      logic [62:0] time_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_out;
      logic        was_killed;
      logic [15:0] client_out;
      logic [31:0] ip_out;
      logic [62:0] age_us;
      logic [1:0]  class_out;
      logic [2:0]  counter_id;
      logic [31:0] counter_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] client;
      logic [31:0] ip;
      logic [62:0] start;
      logic [19:0] limit;
      logic [1:0]  cls;
   } rec_type;

   typedef struct packed {
      logic       latch;
      logic       rd_req;
      logic       rd_sweep;
      logic       exec;
      logic       sweep_start;
      logic       eval;
      logic       kill;
      logic       close;
      logic       snap;
      logic [2:0] snap_id;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       base_zero;
      logic       hit;
      logic       out_free;
   } ctl_stat_type;

endpackage

// ===== src/request_deadline_slot_table_core.sv =====
// Request deadline slot table: a table of SLOTS request slots with deadlines.
// Channels: req_* takes one command beat (register, set class, unregister,
// query, sweep, snapshot, clear); rsp_* returns result beats, rsp_data.last
// marks the final beat of a command; csr_* writes the four limit registers
// (base, proof, wallet, market) and is always ready.
// Flow: a single-result command is accepted in IDLE, reads its slot record
// from the record RAM in FETCH and DECIDE, and loads the result register in
// EXEC; only then is the next command taken, so one command is in flight.
// Snapshot gives five beats, one per cycle while the receiver takes them.
// A sweep visits the slots in turn (RAM read, elapsed/deadline compute,
// compare); a kill beat waits until the result register is free.
// A stalled receiver holds the result register; the controller waits with
// the next beat until it is taken, and no beat is dropped.
// Reset restores the limit registers to their defaults, frees all slots
// and zeroes the counters at once; slot records need no clearing.
`include "request_deadline_slot_table_core_assert.svh"

module request_deadline_slot_table_core #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rdst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rdst_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [19:0]       csr_data
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   rdst_pkg::ctl_cmd_type  ctl;
   rdst_pkg::ctl_stat_type stat;
   logic [IW-1:0]          sweep_idx;

   assign csr_ready = 1'b1;

   rdst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl),
      .sweep_idx (sweep_idx)
   );

   rdst_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .sweep_idx (sweep_idx),
      .stat      (stat)
   );

   `RDST_ASSERT(a_one_load, clock, reset, $onehot0({ctl.exec, ctl.kill, ctl.close, ctl.snap}), "two result loads in one cycle")
   `RDST_ASSERT(a_no_overwrite, clock, reset, (ctl.exec || ctl.kill || ctl.close || ctl.snap) |-> (!rsp_valid || rsp_ready), "result register overwritten while stalled")
   `RDST_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second command taken while one is in flight")
endmodule

// ===== src/rdst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rdst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/rdst_datapath.sv =====
// Datapath: slot record RAM, busy and killed flags, counters, CSRs, result register.
// Depends on rdst_pkg and rdst_ram; driven by rdst_ctrl commands.
module rdst_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rdst_pkg::req_type                      req_data,
   input  logic                                   csr_valid,
   input  logic [1:0]                             csr_index,
   input  logic [19:0]                            csr_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output rdst_pkg::rsp_type                      rsp_data,
   input  rdst_pkg::ctl_cmd_type                  ctl,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] sweep_idx,
   output rdst_pkg::ctl_stat_type                 stat
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RW = $bits(rdst_pkg::rec_type);

   rdst_pkg::req_type req_ff;
   rdst_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [19:0] base_ff, proof_ff, wallet_ff, market_ff;
   logic [SLOTS-1:0] busy_ff, busy_in, expired_ff, expired_in;
   logic [31:0] reg_cnt_ff, reg_cnt_in, comp_cnt_ff, comp_cnt_in;
   logic [31:0] kill_cnt_ff, kill_cnt_in, sweep_cnt_ff, sweep_cnt_in;
   logic [CW-1:0] busy_cnt_ff, busy_cnt_in, kills_ff, kills_in;
   logic [62:0] elapsed_ff;
   logic [29:0] deadline_ff;
   logic        cand_ff;

   logic [IW-1:0]     free_idx, slot_addr, wr_addr;
   logic              any_free, in_range, sel_busy, sel_expired, wr_en;
   logic [19:0]       want, new_limit;
   rdst_pkg::rec_type rd_rec, wr_rec;
   logic [RW-1:0]     ram_rd_data;
   logic              load, out_free;

   assign slot_addr = IW'(req_ff.slot_index);
   assign in_range = (32'(req_ff.slot_index) < 32'(SLOTS));
   assign sel_busy = busy_ff[slot_addr];
   assign sel_expired = expired_ff[slot_addr];
   assign rd_rec = rdst_pkg::rec_type'(ram_rd_data);

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            any_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   always_comb begin
      case (req_ff.method_class)
         rdst_pkg::CLS_WALLET: want = wallet_ff;
         rdst_pkg::CLS_PROOF:  want = proof_ff;
         rdst_pkg::CLS_MARKET: want = market_ff;
         default:              want = 20'd0;
      endcase
      new_limit = (want > rd_rec.limit) ? want : rd_rec.limit;
   end

   rdst_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (RW'(wr_rec)),
      .rd_en   (ctl.rd_req),
      .rd_addr (ctl.rd_sweep ? sweep_idx : slot_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load = ctl.exec || ctl.kill || ctl.close || ctl.snap;

   always_comb begin
      busy_in = busy_ff;
      expired_in = expired_ff;
      reg_cnt_in = reg_cnt_ff;
      comp_cnt_in = comp_cnt_ff;
      kill_cnt_in = kill_cnt_ff;
      sweep_cnt_in = sweep_cnt_ff;
      busy_cnt_in = busy_cnt_ff;
      kills_in = kills_ff;
      wr_en = 1'b0;
      wr_addr = slot_addr;
      wr_rec = rd_rec;
      rsp_in = '0;
      rsp_in.last = 1'b1;
      rsp_in.status = rdst_pkg::ST_REFUSED;

      if (ctl.exec) begin
         case (req_ff.cmd)
            rdst_pkg::CMD_REGISTER: begin
               if (base_ff != 20'd0 && any_free) begin
                  wr_en = 1'b1;
                  wr_addr = free_idx;
                  wr_rec.client = req_ff.client_id;
                  wr_rec.ip = req_ff.ip_addr;
                  wr_rec.start = req_ff.time_us;
                  wr_rec.limit = base_ff;
                  wr_rec.cls = rdst_pkg::CLS_ORDINARY;
                  busy_in[free_idx] = 1'b1;
                  expired_in[free_idx] = 1'b0;
                  reg_cnt_in = reg_cnt_ff + 32'd1;
                  busy_cnt_in = busy_cnt_ff + CW'(1);
                  rsp_in.status = rdst_pkg::ST_DONE;
                  rsp_in.slot_out = 4'(free_idx);
               end
            end
            rdst_pkg::CMD_SET_CLASS: begin
               if (in_range && sel_busy) begin
                  wr_en = 1'b1;
                  wr_rec.limit = new_limit;
                  wr_rec.cls = req_ff.method_class;
                  rsp_in.status = rdst_pkg::ST_DONE;
               end
            end
            rdst_pkg::CMD_UNREGISTER: begin
               if (in_range && sel_busy) begin
                  if (!sel_expired) comp_cnt_in = comp_cnt_ff + 32'd1;
                  busy_in[slot_addr] = 1'b0;
                  expired_in[slot_addr] = 1'b0;
                  busy_cnt_in = busy_cnt_ff - CW'(1);
                  rsp_in.status = rdst_pkg::ST_DONE;
               end
            end
            rdst_pkg::CMD_QUERY: begin
               if (in_range) begin
                  rsp_in.status = rdst_pkg::ST_DONE;
                  rsp_in.was_killed = sel_busy && sel_expired;
               end
            end
            rdst_pkg::CMD_CLEAR: begin
               busy_in = '0;
               expired_in = '0;
               reg_cnt_in = '0;
               comp_cnt_in = '0;
               kill_cnt_in = '0;
               sweep_cnt_in = '0;
               busy_cnt_in = '0;
               rsp_in.status = rdst_pkg::ST_DONE;
            end
            default: begin
               rsp_in.status = rdst_pkg::ST_REFUSED;
            end
         endcase
      end

      if (ctl.sweep_start) begin
         sweep_cnt_in = sweep_cnt_ff + 32'd1;
         kills_in = '0;
      end

      if (ctl.kill) begin
         expired_in[sweep_idx] = 1'b1;
         kill_cnt_in = kill_cnt_ff + 32'd1;
         kills_in = kills_ff + CW'(1);
         rsp_in.status = rdst_pkg::ST_KILL;
         rsp_in.slot_out = 4'(sweep_idx);
         rsp_in.client_out = rd_rec.client;
         rsp_in.ip_out = rd_rec.ip;
         rsp_in.age_us = elapsed_ff;
         rsp_in.class_out = rd_rec.cls;
         rsp_in.last = 1'b0;
      end

      if (ctl.close) begin
         rsp_in.status = rdst_pkg::ST_DONE;
         rsp_in.counter_id = rdst_pkg::CNT_KILLED;
         rsp_in.counter_value = 32'(kills_ff);
      end

      if (ctl.snap) begin
         rsp_in.status = rdst_pkg::ST_COUNTER;
         rsp_in.counter_id = ctl.snap_id;
         rsp_in.last = (ctl.snap_id == rdst_pkg::CNT_BUSY);
         case (ctl.snap_id)
            rdst_pkg::CNT_REGISTERED: rsp_in.counter_value = reg_cnt_ff;
            rdst_pkg::CNT_COMPLETED:  rsp_in.counter_value = comp_cnt_ff;
            rdst_pkg::CNT_KILLED:     rsp_in.counter_value = kill_cnt_ff;
            rdst_pkg::CNT_SWEEPS:     rsp_in.counter_value = sweep_cnt_ff;
            default:                  rsp_in.counter_value = 32'(busy_cnt_ff);
         endcase
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= rdst_pkg::BASE_RESET;
         proof_ff <= rdst_pkg::PROOF_RESET;
         wallet_ff <= rdst_pkg::WALLET_RESET;
         market_ff <= rdst_pkg::MARKET_RESET;
         busy_ff <= '0;
         expired_ff <= '0;
         reg_cnt_ff <= '0;
         comp_cnt_ff <= '0;
         kill_cnt_ff <= '0;
         sweep_cnt_ff <= '0;
         busy_cnt_ff <= '0;
         kills_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rdst_pkg::CSR_BASE:   base_ff <= csr_data;
               rdst_pkg::CSR_PROOF:  proof_ff <= csr_data;
               rdst_pkg::CSR_WALLET: wallet_ff <= csr_data;
               rdst_pkg::CSR_MARKET: market_ff <= csr_data;
               default:              base_ff <= base_ff;
            endcase
         end
         busy_ff <= busy_in;
         expired_ff <= expired_in;
         reg_cnt_ff <= reg_cnt_in;
         comp_cnt_ff <= comp_cnt_in;
         kill_cnt_ff <= kill_cnt_in;
         sweep_cnt_ff <= sweep_cnt_in;
         busy_cnt_ff <= busy_cnt_in;
         kills_ff <= kills_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) req_ff <= req_data;
      if (load) rsp_ff <= rsp_in;
      if (ctl.eval) begin
         elapsed_ff <= req_ff.time_us - rd_rec.start;
         deadline_ff <= 30'(rd_rec.limit) * rdst_pkg::MS_TO_US;
         cand_ff <= busy_ff[sweep_idx] && !expired_ff[sweep_idx]
                    && (req_ff.time_us >= rd_rec.start);
      end
   end

   assign stat.cmd = req_ff.cmd;
   assign stat.base_zero = (base_ff == 20'd0);
   assign stat.hit = cand_ff && (elapsed_ff >= 63'(deadline_ff));
   assign stat.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== src/rdst_ctrl.sv =====
// Controller state machine: sequences commands, sweeps and snapshots.
// Depends on rdst_pkg; drives rdst_datapath through command signals.
module rdst_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  rdst_pkg::ctl_stat_type                 stat,
   output rdst_pkg::ctl_cmd_type                  ctl,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] sweep_idx
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_EXEC = 4'd3;
   localparam logic [3:0] S_SNAP = 4'd4;
   localparam logic [3:0] S_SW_RD = 4'd5;
   localparam logic [3:0] S_SW_EV = 4'd6;
   localparam logic [3:0] S_SW_CK = 4'd7;
   localparam logic [3:0] S_SW_END = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [2:0]    snap_ff, snap_in;
   logic          last_slot;

   assign last_slot = (32'(idx_ff) == 32'(SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      snap_in = snap_ff;
      ctl = '0;
      ctl.snap_id = snap_ff;
      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            ctl.rd_req = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.cmd == rdst_pkg::CMD_SWEEP && !stat.base_zero) begin
               ctl.sweep_start = 1'b1;
               idx_in = '0;
               state_in = S_SW_RD;
            end else if (stat.cmd == rdst_pkg::CMD_SNAPSHOT) begin
               snap_in = rdst_pkg::CNT_REGISTERED;
               state_in = S_SNAP;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               ctl.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SNAP: begin
            if (stat.out_free) begin
               ctl.snap = 1'b1;
               snap_in = snap_ff + 3'd1;
               if (snap_ff == rdst_pkg::CNT_BUSY) state_in = S_IDLE;
            end
         end
         S_SW_RD: begin
            ctl.rd_req = 1'b1;
            ctl.rd_sweep = 1'b1;
            state_in = S_SW_EV;
         end
         S_SW_EV: begin
            ctl.eval = 1'b1;
            state_in = S_SW_CK;
         end
         S_SW_CK: begin
            // hold on a kill until the result register frees up
            if (!stat.hit || stat.out_free) begin
               ctl.kill = stat.hit;
               if (last_slot) begin
                  state_in = S_SW_END;
               end else begin
                  idx_in = idx_ff + IW'(1);
                  state_in = S_SW_RD;
               end
            end
         end
         S_SW_END: begin
            if (stat.out_free) begin
               ctl.close = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         snap_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         snap_ff <= snap_in;
      end
   end

   assign sweep_idx = idx_ff;
endmodule

// ===== tb/tb_request_deadline_slot_table_core.sv =====
// Testbench for request_deadline_slot_table_core: directed and random command beats,
// limit register writes between phases, results checked against a built-in predictor.
// Depends on rdst_pkg and the top level only.
`timescale 1ns / 100ps

class deadline_table_board;
   bit                busy[16];
   bit                expired[16];
   logic [15:0]       client[16];
   logic [31:0]       ip[16];
   logic [62:0]       start[16];
   logic [19:0]       limit[16];
   logic [1:0]        cls[16];
   logic [31:0]       n_registered, n_completed, n_killed, n_sweeps;
   logic [19:0]       base_ms, proof_ms, wallet_ms, market_ms;
   rdst_pkg::rsp_type pending[$];
   int                errors;
   int                checked;

   function new();
      base_ms = rdst_pkg::BASE_RESET;
      proof_ms = rdst_pkg::PROOF_RESET;
      wallet_ms = rdst_pkg::WALLET_RESET;
      market_ms = rdst_pkg::MARKET_RESET;
      wipe();
      errors = 0;
      checked = 0;
   endfunction

   function void wipe();
      for (int i = 0; i < 16; i++) begin
         busy[i] = 0;
         expired[i] = 0;
      end
      n_registered = 0;
      n_completed = 0;
      n_killed = 0;
      n_sweeps = 0;
   endfunction

   function void write_limit(logic [1:0] idx, logic [19:0] v);
      case (idx)
         rdst_pkg::CSR_BASE: base_ms = v;
         rdst_pkg::CSR_PROOF: proof_ms = v;
         rdst_pkg::CSR_WALLET: wallet_ms = v;
         default: market_ms = v;
      endcase
   endfunction

   function void push(logic [1:0] st, logic [3:0] slot = 4'd0, logic kl = 1'b0,
                      logic [2:0] cid = 3'd0, logic [31:0] cval = 32'd0,
                      logic lst = 1'b1);
      rdst_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.slot_out = slot;
      r.was_killed = kl;
      r.counter_id = cid;
      r.counter_value = cval;
      r.last = lst;
      pending.push_back(r);
   endfunction

   function void note_command(rdst_pkg::req_type q);
      logic [19:0]       want;
      logic [62:0]       el;
      logic [31:0]       kills;
      int                idx;
      int                n;
      rdst_pkg::rsp_type r;
      idx = int'(q.slot_index);
      case (q.cmd)
         rdst_pkg::CMD_REGISTER: begin
            n = -1;
            if (base_ms != 0)
               for (int i = 0; i < 16; i++)
                  if (n < 0 && !busy[i]) n = i;
            if (n < 0) push(rdst_pkg::ST_REFUSED);
            else begin
               busy[n] = 1;
               expired[n] = 0;
               client[n] = q.client_id;
               ip[n] = q.ip_addr;
               start[n] = q.time_us;
               limit[n] = base_ms;
               cls[n] = rdst_pkg::CLS_ORDINARY;
               n_registered++;
               push(rdst_pkg::ST_DONE, 4'(n));
            end
         end
         rdst_pkg::CMD_SET_CLASS: begin
            if (!busy[idx]) push(rdst_pkg::ST_REFUSED);
            else begin
               case (q.method_class)
                  rdst_pkg::CLS_WALLET: want = wallet_ms;
                  rdst_pkg::CLS_PROOF: want = proof_ms;
                  rdst_pkg::CLS_MARKET: want = market_ms;
                  default: want = 20'd0;
               endcase
               if (want > limit[idx]) limit[idx] = want;
               cls[idx] = q.method_class;
               push(rdst_pkg::ST_DONE);
            end
         end
         rdst_pkg::CMD_UNREGISTER: begin
            if (!busy[idx]) push(rdst_pkg::ST_REFUSED);
            else begin
               if (!expired[idx]) n_completed++;
               busy[idx] = 0;
               expired[idx] = 0;
               push(rdst_pkg::ST_DONE);
            end
         end
         rdst_pkg::CMD_QUERY: push(rdst_pkg::ST_DONE, 4'd0, busy[idx] && expired[idx]);
         rdst_pkg::CMD_SWEEP: begin
            if (base_ms == 0) push(rdst_pkg::ST_REFUSED);
            else begin
               n_sweeps++;
               kills = 0;
               for (int i = 0; i < 16; i++) begin
                  if (busy[i] && !expired[i] && q.time_us >= start[i]) begin
                     el = q.time_us - start[i];
                     if (el >= 63'(limit[i]) * 63'd1000) begin
                        expired[i] = 1;
                        n_killed++;
                        kills++;
                        r = '0;
                        r.status = rdst_pkg::ST_KILL;
                        r.slot_out = 4'(i);
                        r.client_out = client[i];
                        r.ip_out = ip[i];
                        r.age_us = el;
                        r.class_out = cls[i];
                        pending.push_back(r);
                     end
                  end
               end
               push(rdst_pkg::ST_DONE, 4'd0, 1'b0, rdst_pkg::CNT_KILLED, kills);
            end
         end
         rdst_pkg::CMD_SNAPSHOT: begin
            n = 0;
            for (int i = 0; i < 16; i++) n += int'(busy[i]);
            push(rdst_pkg::ST_COUNTER, 4'd0, 1'b0, rdst_pkg::CNT_REGISTERED, n_registered,
                 1'b0);
            push(rdst_pkg::ST_COUNTER, 4'd0, 1'b0, rdst_pkg::CNT_COMPLETED, n_completed,
                 1'b0);
            push(rdst_pkg::ST_COUNTER, 4'd0, 1'b0, rdst_pkg::CNT_KILLED, n_killed, 1'b0);
            push(rdst_pkg::ST_COUNTER, 4'd0, 1'b0, rdst_pkg::CNT_SWEEPS, n_sweeps, 1'b0);
            push(rdst_pkg::ST_COUNTER, 4'd0, 1'b0, rdst_pkg::CNT_BUSY, 32'(n), 1'b1);
         end
         rdst_pkg::CMD_CLEAR: begin
            wipe();
            push(rdst_pkg::ST_DONE);
         end
         default: push(rdst_pkg::ST_REFUSED);
      endcase
   endfunction

   task report(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch %0s: got %0h, expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   task check_result(rdst_pkg::rsp_type got);
      rdst_pkg::rsp_type w;
      if (pending.size() == 0) begin
         report("unexpected beat", 128'(got.status), 128'd0);
         return;
      end
      w = pending.pop_front();
      checked++;
      if (got.status !== w.status) report("status", 128'(got.status), 128'(w.status));
      if (got.slot_out !== w.slot_out)
         report("slot_out", 128'(got.slot_out), 128'(w.slot_out));
      if (got.was_killed !== w.was_killed)
         report("was_killed", 128'(got.was_killed), 128'(w.was_killed));
      if (got.client_out !== w.client_out)
         report("client_out", 128'(got.client_out), 128'(w.client_out));
      if (got.ip_out !== w.ip_out) report("ip_out", 128'(got.ip_out), 128'(w.ip_out));
      if (got.age_us !== w.age_us) report("age_us", 128'(got.age_us), 128'(w.age_us));
      if (got.class_out !== w.class_out)
         report("class_out", 128'(got.class_out), 128'(w.class_out));
      if (got.counter_id !== w.counter_id)
         report("counter_id", 128'(got.counter_id), 128'(w.counter_id));
      if (got.counter_value !== w.counter_value)
         report("counter_value", 128'(got.counter_value), 128'(w.counter_value));
      if (got.last !== w.last) report("last", 128'(got.last), 128'(w.last));
   endtask
endclass

module tb_request_deadline_slot_table_core;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   rdst_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   rdst_pkg::rsp_type rsp_data;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [1:0]        csr_index = rdst_pkg::CSR_BASE;
   logic [19:0]       csr_data = '0;

   deadline_table_board board = new();
   bit          calm = 0;
   int          n_cmds = 0;
   logic [62:0] now_us = 63'd5000;

   request_deadline_slot_table_core u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // receiver: random stalls except in calm stretches
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      rsp_ready <= calm || ($urandom_range(99) >= 32);
   end

   // valid stays up after a beat only when the next beat follows at once
   task send(rdst_pkg::req_type q);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(q);
      n_cmds++;
   endtask

   task cmd(logic [2:0] c, logic [3:0] slot = 4'd0, logic [1:0] mc = 2'd0,
            logic [62:0] t = 63'd0, logic [15:0] cl = 16'd0, logic [31:0] a = 32'd0);
      rdst_pkg::req_type q;
      q.cmd = c;
      q.client_id = cl;
      q.ip_addr = a;
      q.slot_index = slot;
      q.method_class = mc;
      q.time_us = t;
      send(q);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [19:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_limit(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task random_phase(int count);
      int r;
      logic [62:0] t;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         now_us += 63'($urandom_range(3000, 1));
         t = now_us;
         if (r < 30)
            cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, t, 16'($urandom), $urandom);
         else if (r < 45)
            cmd(rdst_pkg::CMD_SET_CLASS, 4'($urandom), 2'($urandom));
         else if (r < 58)
            cmd(rdst_pkg::CMD_UNREGISTER, 4'($urandom));
         else if (r < 68)
            cmd(rdst_pkg::CMD_QUERY, 4'($urandom));
         else if (r < 88)
            cmd(rdst_pkg::CMD_SWEEP, 4'd0, 2'd0,
                (r < 72) ? 63'({$urandom, $urandom}) : t);
         else if (r < 97)
            cmd(rdst_pkg::CMD_SNAPSHOT);
         else if (r < 99)
            cmd(rdst_pkg::CMD_CLEAR);
         else
            cmd(CMD_UNUSED, 4'($urandom), 2'($urandom), 63'({$urandom, $urandom}),
                16'($urandom), $urandom);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tiny limits so kills happen in microseconds-scale time
      write_csr(rdst_pkg::CSR_BASE, 20'd1);
      write_csr(rdst_pkg::CSR_PROOF, 20'd3);
      write_csr(rdst_pkg::CSR_WALLET, 20'd2);
      write_csr(rdst_pkg::CSR_MARKET, 20'hFFFFF);
      cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, 63'd0, 16'hFFFF, 32'hFFFFFFFF);
      cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, 63'h7FFFFFFFFFFFFFFF, 16'h0000, 32'h0);
      cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, 63'd100, 16'h1234, 32'hC0A80001);
      cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, 63'd100, 16'h5678, 32'h0A000001);
      cmd(rdst_pkg::CMD_SET_CLASS, 4'd2, rdst_pkg::CLS_PROOF);
      cmd(rdst_pkg::CMD_SET_CLASS, 4'd3, rdst_pkg::CLS_MARKET);
      cmd(rdst_pkg::CMD_SET_CLASS, 4'd2, rdst_pkg::CLS_WALLET);   // must not lower the limit
      cmd(rdst_pkg::CMD_SET_CLASS, 4'd0, rdst_pkg::CLS_ORDINARY);
      cmd(rdst_pkg::CMD_SET_CLASS, 4'd15, rdst_pkg::CLS_WALLET);  // free slot, refused
      cmd(rdst_pkg::CMD_SWEEP, 4'd0, 2'd0, 63'd1000);   // exactly at deadline for slot 0
      cmd(rdst_pkg::CMD_SWEEP, 4'd0, 2'd0, 63'd3100);   // slot 1 started in the future
      cmd(rdst_pkg::CMD_QUERY, 4'd0);
      cmd(rdst_pkg::CMD_QUERY, 4'd15);
      cmd(rdst_pkg::CMD_UNREGISTER, 4'd0);              // killed, not counted complete
      cmd(rdst_pkg::CMD_UNREGISTER, 4'd1);
      cmd(rdst_pkg::CMD_UNREGISTER, 4'd1);              // already free
      cmd(rdst_pkg::CMD_SNAPSHOT);
      cmd(CMD_UNUSED, 4'hF, 2'd3, 63'd1, 16'd1, 32'd1);
      for (int i = 0; i < 16; i++)
         cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, 63'd50, 16'(i), 32'(i));
      cmd(rdst_pkg::CMD_REGISTER);                       // table full
      cmd(rdst_pkg::CMD_SWEEP, 4'd0, 2'd0, 63'h7FFFFFFFFFFFFFFF); // every slot overdue
      cmd(rdst_pkg::CMD_CLEAR);
      cmd(rdst_pkg::CMD_SNAPSHOT);
      drain();

      // base limit zero: tracking disabled
      write_csr(rdst_pkg::CSR_BASE, 20'd0);
      cmd(rdst_pkg::CMD_REGISTER, 4'd0, 2'd0, 63'd5);
      cmd(rdst_pkg::CMD_SWEEP, 4'd0, 2'd0, 63'd5);
      cmd(rdst_pkg::CMD_SNAPSHOT);
      drain();

      // long calm stretch with small limits
      calm = 1;
      write_csr(rdst_pkg::CSR_BASE, 20'd2);
      write_csr(rdst_pkg::CSR_PROOF, 20'd1);
      write_csr(rdst_pkg::CSR_WALLET, 20'd4);
      write_csr(rdst_pkg::CSR_MARKET, 20'd6);
      random_phase(30);
      calm = 0;
      drain();

      // large base, proof and market limits, small wallet limit
      write_csr(rdst_pkg::CSR_BASE, 20'd600000);
      write_csr(rdst_pkg::CSR_PROOF, 20'd600000);
      write_csr(rdst_pkg::CSR_WALLET, 20'd1);
      write_csr(rdst_pkg::CSR_MARKET, 20'd600000);
      random_phase(20);
      drain();

      write_csr(rdst_pkg::CSR_BASE, 20'd3);
      write_csr(rdst_pkg::CSR_MARKET, 20'd1);
      random_phase(30);
      drain();

      $display("Ran %0d commands, %0d result beats checked over disabled, tiny and maximal limits",
               n_cmds, board.checked);
      if (board.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/rdst_pkg.sv
src/rdst_ram.sv
src/rdst_datapath.sv
src/rdst_ctrl.sv
src/request_deadline_slot_table_core.sv
tb/tb_request_deadline_slot_table_core.sv
